// ===== src/sorted_interval_coalescer_macros.svh =====
// ----------------------------------------------------------------------------
// sorted interval coalescer assertion macros
// shared clocked assertion forms with reset masking
// ----------------------------------------------------------------------------
`ifndef SORTED_INTERVAL_COALESCER_MACROS_SVH
`define SORTED_INTERVAL_COALESCER_MACROS_SVH

// same-cycle implication
`define SIC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// shared constants for the sorted interval coalescer
// ----------------------------------------------------------------------------
package sic_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 32;
    localparam int CHROM_BITS_DEF = 10;

    // result queue depth, power of two, at least two results per request
    localparam int OUT_DEPTH = 4;

endpackage

// ===== src/sic_region_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_region_if
// input interval channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sic_region_if #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int CHROM_BITS = sic_pkg::CHROM_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [CHROM_BITS-1:0] region_chrom;
    logic [COORD_BITS-1:0] region_start;
    logic [COORD_BITS-1:0] region_end;
    logic                  stream_last;

    modport source (
        output valid, region_chrom, region_start, region_end, stream_last,
        input  ready
    );

    modport sink (
        input  valid, region_chrom, region_start, region_end, stream_last,
        output ready
    );
endinterface

// ===== src/sic_contig_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_contig_if
// merged contig result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sic_contig_if #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int CHROM_BITS = sic_pkg::CHROM_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [CHROM_BITS-1:0] contig_chrom;
    logic [COORD_BITS-1:0] contig_start;
    logic [COORD_BITS-1:0] contig_end;
    logic                  run_last;

    modport source (
        output valid, contig_chrom, contig_start, contig_end, run_last,
        input  ready
    );

    modport sink (
        input  valid, contig_chrom, contig_start, contig_end, run_last,
        output ready
    );
endinterface

// ===== src/sorted_interval_coalescer.sv =====
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, and any contig it closes or flushes is
//   written to the result queue and offered from there; a flushed contig queues behind a closed one
// throughput: one request per cycle while the output drains and two queue slots are free, bounded by the output
//   port's one contig per cycle and the four-entry result queue
// reset: asynchronous active low, no open contig, result queue empty, nothing held
// ----------------------------------------------------------------------------
// sorted_interval_coalescer
// merges sorted overlapping or touching intervals into contigs, one open contig
// ----------------------------------------------------------------------------
module sorted_interval_coalescer #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int CHROM_BITS = sic_pkg::CHROM_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sic_region_if.sink   region,
    sic_contig_if.source contig
);

    localparam int DEPTH = sic_pkg::OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // input register: one request held for the merge logic
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic [CHROM_BITS-1:0] in_chrom_reg;
    logic [COORD_BITS-1:0] in_start_reg;
    logic [COORD_BITS-1:0] in_end_reg;
    logic                  in_last_reg;

    // open contig state
    logic                  open_valid_reg, open_valid_next;
    logic [CHROM_BITS-1:0] open_chrom_reg, open_chrom_next;
    logic [COORD_BITS-1:0] open_start_reg, open_start_next;
    logic [COORD_BITS-1:0] open_end_reg,   open_end_next;

    // result queue
    logic [CHROM_BITS-1:0] q_chrom_reg [DEPTH];
    logic [COORD_BITS-1:0] q_start_reg [DEPTH];
    logic [COORD_BITS-1:0] q_end_reg   [DEPTH];
    logic                  q_last_reg  [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg,  count_next;

    logic                  room;
    logic                  proc;
    logic                  in_fire;
    logic                  out_fire;
    logic                  nonempty;
    logic                  merge;
    logic                  emit_old;
    logic                  flush;
    logic                  post_valid;
    logic [CHROM_BITS-1:0] post_chrom;
    logic [COORD_BITS-1:0] post_start;
    logic [COORD_BITS-1:0] post_end;
    logic [PTR_W-1:0]      wr_idx_flush;
    logic [CNT_W-1:0]      n_wr;

    // two free slots guarantee the worst case of two contigs per request
    assign room     = count_reg <= CNT_W'(DEPTH - 2);
    assign proc     = in_valid_reg && room;
    assign region.ready = !in_valid_reg || proc;
    assign in_fire  = region.valid && region.ready;

    assign contig.valid        = count_reg != '0;
    assign contig.contig_chrom = q_chrom_reg[rd_ptr_reg];
    assign contig.contig_start = q_start_reg[rd_ptr_reg];
    assign contig.contig_end   = q_end_reg[rd_ptr_reg];
    assign contig.run_last     = q_last_reg[rd_ptr_reg];
    assign out_fire = contig.valid && contig.ready;

    // ------------------------------------------------------------------
    // merge decision: one compare set and a min/max against the open contig
    // ------------------------------------------------------------------
    always_comb
    begin
        // empty intervals are dropped but may still flush
        nonempty = in_end_reg > in_start_reg;
        // overlapping or touching on either side merges
        merge    = open_valid_reg && (in_chrom_reg == open_chrom_reg)
                   && (in_start_reg <= open_end_reg) && (in_end_reg >= open_start_reg);
        emit_old = nonempty && !merge && open_valid_reg;

        post_valid = open_valid_reg;
        post_chrom = open_chrom_reg;
        post_start = open_start_reg;
        post_end   = open_end_reg;
        if (nonempty)
        begin
            if (merge)
            begin
                if (in_start_reg < open_start_reg)
                begin
                    post_start = in_start_reg;
                end
                if (in_end_reg > open_end_reg)
                begin
                    post_end = in_end_reg;
                end
            end
            else
            begin
                post_valid = 1'b1;
                post_chrom = in_chrom_reg;
                post_start = in_start_reg;
                post_end   = in_end_reg;
            end
        end
        flush = in_last_reg && post_valid;

        open_valid_next = open_valid_reg;
        open_chrom_next = open_chrom_reg;
        open_start_next = open_start_reg;
        open_end_next   = open_end_reg;
        if (proc)
        begin
            if (flush)
            begin
                // back to the reset state for a fresh stream
                open_valid_next = 1'b0;
                open_chrom_next = '0;
                open_start_next = '0;
                open_end_next   = '0;
            end
            else
            begin
                open_valid_next = post_valid;
                open_chrom_next = post_chrom;
                open_start_next = post_start;
                open_end_next   = post_end;
            end
        end
    end

    // ------------------------------------------------------------------
    // queue bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_idx_flush = wr_ptr_reg + PTR_W'(emit_old);
        n_wr         = proc ? (CNT_W'(emit_old) + CNT_W'(flush)) : '0;
        wr_ptr_next  = wr_ptr_reg + n_wr[PTR_W-1:0];
        rd_ptr_next  = rd_ptr_reg + PTR_W'(out_fire);
        count_next   = count_reg + n_wr - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            open_valid_reg <= 1'b0;
            open_chrom_reg <= '0;
            open_start_reg <= '0;
            open_end_reg   <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            open_valid_reg <= open_valid_next;
            open_chrom_reg <= open_chrom_next;
            open_start_reg <= open_start_next;
            open_end_reg   <= open_end_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_chrom_reg <= region.region_chrom;
            in_start_reg <= region.region_start;
            in_end_reg   <= region.region_end;
            in_last_reg  <= region.stream_last;
        end
        if (proc && emit_old)
        begin
            // closed contig goes first, last only when nothing is flushed after it
            q_chrom_reg[wr_ptr_reg] <= open_chrom_reg;
            q_start_reg[wr_ptr_reg] <= open_start_reg;
            q_end_reg[wr_ptr_reg]   <= open_end_reg;
            q_last_reg[wr_ptr_reg]  <= !flush;
        end
        if (proc && flush)
        begin
            q_chrom_reg[wr_idx_flush] <= post_chrom;
            q_start_reg[wr_idx_flush] <= post_start;
            q_end_reg[wr_idx_flush]   <= post_end;
            q_last_reg[wr_idx_flush]  <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "sorted_interval_coalescer_macros.svh"

    `SIC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `SIC_ASSERT_SAME(a_proc_room, clk, rst_n, proc, count_reg <= CNT_W'(DEPTH - 2), "no room for two contigs")
    `SIC_ASSERT_NEXT(a_flush_clears, clk, rst_n, proc && in_last_reg, !open_valid_reg, "open contig survived flush")
    `SIC_ASSERT_NEXT(a_emit_shows, clk, rst_n, proc && (emit_old || flush), contig.valid, "emitted contig not offered")

endmodule
